/* rtl/lmts_pkg.sv */
// Shared types and timing constants for the LCD mode timing sequencer.
`timescale 1ns / 1ps

package lmts_pkg;

  // Number of lines drawn per frame before vertical blank starts.
  localparam logic [7:0]  VISIBLE_LINES = 8'd144;

  localparam logic [15:0] OAM_DOTS      = 16'd79;
  localparam logic [15:0] XFER_DOTS     = 16'd172;
  localparam logic [15:0] HBLANK_DOTS   = 16'd205;
  localparam logic [15:0] VBLANK_DOTS   = 16'd4560;
  localparam logic [15:0] LINE_DOTS     = 16'd456;
  localparam int          VBLANK_LINES  = 4560 / 456;

  localparam logic [15:0] DOT_MAX       = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [1:0]  CFG_LINE_COMPARE = 2'd0;
  localparam logic [1:0]  CFG_HBLANK_EN    = 2'd1;
  localparam logic [1:0]  CFG_VBLANK_EN    = 2'd2;
  localparam logic [1:0]  CFG_OAM_EN       = 2'd3;

  typedef enum logic [1:0] {
    MODE_HORIZ_BLANK = 2'd0,
    MODE_VERT_BLANK  = 2'd1,
    MODE_OAM         = 2'd2,
    MODE_XFER        = 2'd3
  } lcd_mode_e;

  typedef struct packed {
    logic [15:0] dot_cnt;
    lcd_mode_e   mode;
    logic [7:0]  line;
  } lmts_state_t;

  typedef struct packed {
    logic [7:0] line_compare;
    logic       hblank_en;
    logic       vblank_en;
    logic       oam_en;
  } lmts_cfg_t;

  typedef struct packed {
    lcd_mode_e  lcd_mode;
    logic [7:0] current_line;
    logic       coincidence;
    logic       vblank_irq;
    logic       stat_irq;
    logic       line_done;
    logic [7:0] drawn_line;
    logic       frame_done;
  } lmts_result_t;

endpackage

/* rtl/lcd_mode_timing_sequencer_top.sv */
// Top level of the LCD mode timing sequencer: handshakes, state and result registers.
`timescale 1ns / 1ps

// Usage: each input transaction on in_valid_i/in_ready_o carries dots_i, the
// number of dot clocks since the previous transaction. The block adds them to
// its dot counter, makes at most one LCD mode change and returns exactly one
// result transaction on out_valid_o/out_ready_i with the mode, current line,
// line-compare flag, interrupt pulses and line/frame completion flags.
// The transaction is captured in an input register; the mode update runs between
// that register and the result register, and the result is registered once the
// result register is free or drains. One transaction is taken every cycle while
// results are taken; the dot-counter update loop is what sets this rate. When the
// receiver stalls, the result register holds and the input register fills, after
// which in_ready_o drops until the result is taken; nothing is lost or repeated.
// Reset clears the dot counter and line to zero, starts in OAM search and clears
// all configuration registers. The user is to write configuration through
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is idle; it is not enforced.
module lcd_mode_timing_sequencer_top
  import lmts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] dots_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] lcd_mode_o,
  output logic [7:0] current_line_o,
  output logic       coincidence_o,
  output logic       vblank_irq_o,
  output logic       stat_irq_o,
  output logic       line_done_o,
  output logic [7:0] drawn_line_o,
  output logic       frame_done_o
);

  lmts_cfg_t    cfg_q;
  lmts_state_t  state_q, state_d;
  lmts_result_t res_q, res_d;
  logic         in_valid_q;
  logic [7:0]   dots_q;
  logic         out_valid_q;
  logic         step;

  // The input stage moves on whenever the result register is free or drains.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_COMPARE: cfg_q.line_compare <= cfg_wdata_i;
        CFG_HBLANK_EN:    cfg_q.hblank_en    <= cfg_wdata_i[0];
        CFG_VBLANK_EN:    cfg_q.vblank_en    <= cfg_wdata_i[0];
        CFG_OAM_EN:       cfg_q.oam_en       <= cfg_wdata_i[0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      dots_q <= dots_i;
    end
  end

  lmts_step u_step (
    .cur_i  (state_q),
    .cfg_i  (cfg_q),
    .dots_i (dots_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.dot_cnt <= '0;
      state_q.mode    <= MODE_OAM;
      state_q.line    <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (step) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lcd_mode_o     = res_q.lcd_mode;
  assign current_line_o = res_q.current_line;
  assign coincidence_o  = res_q.coincidence;
  assign vblank_irq_o   = res_q.vblank_irq;
  assign stat_irq_o     = res_q.stat_irq;
  assign line_done_o    = res_q.line_done;
  assign drawn_line_o   = res_q.drawn_line;
  assign frame_done_o   = res_q.frame_done;

`ifndef SYNTHESIS
  a_line_done_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.line_done |-> res_q.drawn_line < VISIBLE_LINES)
    else $error("drawn line outside the visible range");

  a_frame_done_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_done |->
      res_q.lcd_mode == MODE_VERT_BLANK && res_q.vblank_irq && res_q.line_done)
    else $error("frame completion without vertical blank entry");

  a_vblank_irq_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.vblank_irq |-> res_q.lcd_mode == MODE_VERT_BLANK)
    else $error("vertical blank interrupt outside vertical blank");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(state_q))
    else $error("sequencer state changed without a transaction");
`endif

endmodule

/* rtl/lmts_step.sv */
// Next-state and result logic for one dot batch of the LCD mode sequencer.
`timescale 1ns / 1ps

module lmts_step
  import lmts_pkg::*;
(
  input  lmts_state_t  cur_i,
  input  lmts_cfg_t    cfg_i,
  input  logic [7:0]   dots_i,
  output lmts_state_t  nxt_o,
  output lmts_result_t res_o
);

  logic [16:0] sum;
  logic [15:0] dot_sat;
  logic [3:0]  vb_quot;
  logic [7:0]  vb_line;
  logic [7:0]  line_inc;
  logic        enter;
  lcd_mode_e   new_mode;

  assign sum      = {1'b0, cur_i.dot_cnt} + 17'(dots_i);
  assign dot_sat  = sum[16] ? DOT_MAX : sum[15:0];
  assign line_inc = cur_i.line + 8'd1;

  // Line within vertical blank: counter / 456, found by comparing against
  // the line boundaries. Only used while the counter is below 4560.
  always_comb begin
    vb_quot = 4'd0;
    for (int k = 1; k < VBLANK_LINES; k++) begin
      if (dot_sat >= 16'(k * int'(LINE_DOTS))) begin
        vb_quot = vb_quot + 4'd1;
      end
    end
  end

  assign vb_line = VISIBLE_LINES + 8'(vb_quot);

  always_comb begin
    nxt_o         = cur_i;
    nxt_o.dot_cnt = dot_sat;
    enter         = 1'b0;
    new_mode      = cur_i.mode;
    res_o         = '0;

    case (cur_i.mode)
      MODE_OAM: begin
        if (dot_sat >= OAM_DOTS) begin
          nxt_o.dot_cnt = dot_sat - OAM_DOTS;
          new_mode      = MODE_XFER;
          enter         = 1'b1;
        end
      end
      MODE_XFER: begin
        if (dot_sat >= XFER_DOTS) begin
          nxt_o.dot_cnt = dot_sat - XFER_DOTS;
          new_mode      = MODE_HORIZ_BLANK;
          enter         = 1'b1;
        end
      end
      MODE_HORIZ_BLANK: begin
        if (dot_sat >= HBLANK_DOTS) begin
          nxt_o.dot_cnt = dot_sat - HBLANK_DOTS;
          if (cur_i.line < VISIBLE_LINES) begin
            res_o.line_done  = 1'b1;
            res_o.drawn_line = cur_i.line;
          end
          nxt_o.line = line_inc;
          enter      = 1'b1;
          if (line_inc >= VISIBLE_LINES) begin
            new_mode         = MODE_VERT_BLANK;
            res_o.frame_done = 1'b1;
          end else begin
            new_mode = MODE_OAM;
          end
        end
      end
      MODE_VERT_BLANK: begin
        if (dot_sat < VBLANK_DOTS) begin
          nxt_o.line = vb_line;
        end else begin
          nxt_o.dot_cnt = dot_sat - VBLANK_DOTS;
          nxt_o.line    = 8'd0;
          new_mode      = MODE_OAM;
          enter         = 1'b1;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase

    // Every transition above moves to a different mode, so each one is an entry.
    if (enter) begin
      nxt_o.mode       = new_mode;
      res_o.vblank_irq = (new_mode == MODE_VERT_BLANK);
      res_o.stat_irq   = (new_mode == MODE_HORIZ_BLANK && cfg_i.hblank_en) ||
                         (new_mode == MODE_VERT_BLANK  && cfg_i.vblank_en) ||
                         (new_mode == MODE_OAM         && cfg_i.oam_en);
    end

    res_o.lcd_mode     = nxt_o.mode;
    res_o.current_line = nxt_o.line;
    res_o.coincidence  = (nxt_o.line == cfg_i.line_compare);
  end

endmodule

/* tb/lcd_timing_checker.sv */
// Checker for the LCD mode timing sequencer: predicts each result and compares it.
`timescale 1ns / 1ps

module lcd_timing_checker
  import lmts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,

  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  dots_i,

  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  lcd_mode_i,
  input  logic [7:0]  current_line_i,
  input  logic        coincidence_i,
  input  logic        vblank_irq_i,
  input  logic        stat_irq_i,
  input  logic        line_done_i,
  input  logic [7:0]  drawn_line_i,
  input  logic        frame_done_i,

  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  // Mirror of the timing state and configuration.
  logic [15:0] dot_cnt;
  lcd_mode_e   mode;
  logic [7:0]  line;
  logic [7:0]  cmp_line;
  logic        hblank_en;
  logic        vblank_en;
  logic        oam_en;

  lmts_result_t expected_status_q[$];

  // Adds one batch of dots and makes at most one mode change.
  task automatic advance_timing(input logic [7:0] dots, output lmts_result_t status);
    logic [16:0]  sum;
    lmts_result_t res;
    res = '0;
    sum = {1'b0, dot_cnt} + {9'd0, dots};
    dot_cnt = sum[16] ? DOT_MAX : sum[15:0];
    case (mode)
      MODE_OAM: begin
        if (dot_cnt >= OAM_DOTS) begin
          dot_cnt = dot_cnt - OAM_DOTS;
          mode = MODE_XFER;
        end
      end
      MODE_XFER: begin
        if (dot_cnt >= XFER_DOTS) begin
          dot_cnt = dot_cnt - XFER_DOTS;
          mode = MODE_HORIZ_BLANK;
          res.stat_irq = hblank_en;
        end
      end
      MODE_HORIZ_BLANK: begin
        if (dot_cnt >= HBLANK_DOTS) begin
          dot_cnt = dot_cnt - HBLANK_DOTS;
          // Lines past the visible area still advance but are not drawn.
          if (line < VISIBLE_LINES) begin
            res.line_done = 1'b1;
            res.drawn_line = line;
          end
          line = line + 8'd1;
          if (line >= VISIBLE_LINES) begin
            mode = MODE_VERT_BLANK;
            res.vblank_irq = 1'b1;
            res.stat_irq = vblank_en;
            res.frame_done = 1'b1;
          end else begin
            mode = MODE_OAM;
            res.stat_irq = oam_en;
          end
        end
      end
      MODE_VERT_BLANK: begin
        if (dot_cnt < VBLANK_DOTS) begin
          line = 8'(dot_cnt / LINE_DOTS) + VISIBLE_LINES;
        end else begin
          mode = MODE_OAM;
          res.stat_irq = oam_en;
          dot_cnt = dot_cnt - VBLANK_DOTS;
          line = '0;
        end
      end
    endcase
    res.lcd_mode = mode;
    res.current_line = line;
    res.coincidence = (line == cmp_line);
    status = res;
  endtask

  function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lmts_result_t predicted;
    if (!rst_ni) begin
      dot_cnt = '0;
      mode = MODE_OAM;
      line = '0;
      cmp_line = '0;
      hblank_en = 1'b0;
      vblank_en = 1'b0;
      oam_en = 1'b0;
      expected_status_q.delete();
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LINE_COMPARE: cmp_line = cfg_wdata_i;
          CFG_HBLANK_EN:    hblank_en = cfg_wdata_i[0];
          CFG_VBLANK_EN:    vblank_en = cfg_wdata_i[0];
          CFG_OAM_EN:       oam_en = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        advance_timing(dots_i, predicted);
        expected_status_q.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: result transaction with nothing predicted, actual mode %0d line %0d",
                   $time, lcd_mode_i, current_line_i);
          mismatch_count_o++;
        end else begin
          predicted = expected_status_q.pop_front();
          compare_field("lcd_mode", 8'(predicted.lcd_mode), 8'(lcd_mode_i));
          compare_field("current_line", predicted.current_line, current_line_i);
          compare_field("coincidence", 8'(predicted.coincidence), 8'(coincidence_i));
          compare_field("vblank_irq", 8'(predicted.vblank_irq), 8'(vblank_irq_i));
          compare_field("stat_irq", 8'(predicted.stat_irq), 8'(stat_irq_i));
          compare_field("line_done", 8'(predicted.line_done), 8'(line_done_i));
          compare_field("drawn_line", predicted.drawn_line, drawn_line_i);
          compare_field("frame_done", 8'(predicted.frame_done), 8'(frame_done_i));
        end
      end
      pending_o <= expected_status_q.size();
    end
  end

endmodule

/* tb/lcd_mode_timing_sequencer_top_test.sv */
// Testbench top for the LCD mode timing sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module lcd_mode_timing_sequencer_top_test;
  import lmts_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 160;
  localparam int LONG_ITEMS     = 900;

  typedef enum logic [1:0] {
    DOTS_UNIFORM,
    DOTS_SMALL,
    DOTS_HIGH,
    DOTS_MAX
  } dots_profile_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = CFG_LINE_COMPARE;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] dots_i      = 8'd0;
  logic       out_ready_i = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] lcd_mode_o;
  logic [7:0] current_line_o;
  logic       coincidence_o;
  logic       vblank_irq_o;
  logic       stat_irq_o;
  logic       line_done_o;
  logic [7:0] drawn_line_o;
  logic       frame_done_o;

  int unsigned result_mismatches;
  int unsigned predictions_pending;
  int unsigned quiet_cycles = 0;
  int          calm_left = 0;
  bit          hold_off_req = 1'b0;

  lcd_mode_timing_sequencer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .dots_i        (dots_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lcd_mode_o    (lcd_mode_o),
    .current_line_o(current_line_o),
    .coincidence_o (coincidence_o),
    .vblank_irq_o  (vblank_irq_o),
    .stat_irq_o    (stat_irq_o),
    .line_done_o   (line_done_o),
    .drawn_line_o  (drawn_line_o),
    .frame_done_o  (frame_done_o)
  );

  lcd_timing_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .dots_i          (dots_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lcd_mode_i      (lcd_mode_o),
    .current_line_i  (current_line_o),
    .coincidence_i   (coincidence_o),
    .vblank_irq_i    (vblank_irq_o),
    .stat_irq_i      (stat_irq_o),
    .line_done_i     (line_done_o),
    .drawn_line_i    (drawn_line_o),
    .frame_done_i    (frame_done_o),
    .mismatch_count_o(result_mismatches),
    .pending_o       (predictions_pending)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [7:0] pick_dots(dots_profile_e profile);
    case (profile)
      DOTS_SMALL: return 8'($urandom_range(0, 31));
      DOTS_HIGH:  return 8'($urandom_range(128, 255));
      DOTS_MAX:   return ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : 8'd255;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    int run;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = random_gap();
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      repeat (run) @(posedge clk_i);
    end
  end

  // Offers one transaction and returns at the edge where it is taken.
  task automatic push_dots(input logic [7:0] d);
    int gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = random_gap();
      if ($urandom_range(0, 59) == 0) calm_left = $urandom_range(30, 120);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    dots_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (predictions_pending != 0);
  endtask

  // Writes all four registers on consecutive cycles; noisy upper bits on the enables.
  task automatic write_cfg(input logic [7:0] cmp, input logic hb, input logic vb,
                           input logic oam, input bit noisy);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_LINE_COMPARE;
    cfg_wdata_i <= cmp;
    @(posedge clk_i);
    cfg_idx_i <= CFG_HBLANK_EN;
    cfg_wdata_i <= {noisy ? 7'($urandom) : 7'd0, hb};
    @(posedge clk_i);
    cfg_idx_i <= CFG_VBLANK_EN;
    cfg_wdata_i <= {noisy ? 7'($urandom) : 7'd0, vb};
    @(posedge clk_i);
    cfg_idx_i <= CFG_OAM_EN;
    cfg_wdata_i <= {noisy ? 7'($urandom) : 7'd0, oam};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] cmp, input logic hb, input logic vb,
                           input logic oam, input bit noisy, input dots_profile_e profile,
                           input int count, input bit pressure);
    wait_drained();
    write_cfg(cmp, hb, vb, oam, noisy);
    if (pressure) begin
      hold_off_req = 1'b1;
      calm_left = 250;
      // Start offering only once the receiver has begun its hold-off.
      while (hold_off_req) @(posedge clk_i);
    end
    repeat (count) push_dots(pick_dots(profile));
    in_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] directed_dots [$] = '{8'd0, 8'd255, 8'd0, 8'd78, 8'd1, 8'd171, 8'd1,
                                      8'd204, 8'd1, 8'h55, 8'hAA, 8'h80, 8'h7F, 8'd255,
                                      8'd255, 8'd255, 8'd0, 8'd79, 8'd172, 8'd205};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_cfg(8'd0, 1'b1, 1'b1, 1'b1, 1'b0);
    foreach (directed_dots[i]) push_dots(directed_dots[i]);
    in_valid_i <= 1'b0;

    // The first random phase also exercises back-pressure on the input channel.
    run_phase(8'd255, 1'b0, 1'b0, 1'b0, 1'b0, DOTS_UNIFORM, PHASE_ITEMS, 1'b1);
    run_phase(8'd144, 1'b1, 1'b1, 1'b1, 1'b1, DOTS_SMALL, PHASE_ITEMS, 1'b0);
    run_phase(8'($urandom_range(0, 153)), 1'($urandom), 1'($urandom), 1'($urandom),
              1'b1, DOTS_UNIFORM, PHASE_ITEMS, 1'b0);
    run_phase(8'd0, 1'b1, 1'b0, 1'b1, 1'b0, DOTS_UNIFORM, PHASE_ITEMS, 1'b0);
    run_phase(8'($urandom_range(0, 153)), 1'($urandom), 1'($urandom), 1'($urandom),
              1'b1, DOTS_HIGH, PHASE_ITEMS, 1'b0);
    // Sustained large batches build up the dot counter until it saturates.
    run_phase(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b1, 1'b1, DOTS_MAX, LONG_ITEMS,
              1'b0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (result_mismatches == 0 && predictions_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lmts_pkg.sv
rtl/lmts_step.sv
rtl/lcd_mode_timing_sequencer_top.sv
tb/lcd_timing_checker.sv
tb/lcd_mode_timing_sequencer_top_test.sv
